// ===== design/i2cmbc_pkg.sv =====
package i2cmbc_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_TICKS = 1'b0,
		CFG_ACK_TIMEOUT = 1'b1
	} cfg_idx_t;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd2;
	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

	// Command codes
	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_STOP  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	// Bus sequencer states
	typedef enum logic [3:0] {
		S_IDLE    = 4'd0,
		S_ST_HI   = 4'd1,
		S_ST_LO   = 4'd2,
		S_SP_LO   = 4'd3,
		S_SP_HI   = 4'd4,
		S_WR_SET  = 4'd5,
		S_WR_HI   = 4'd6,
		S_WR_LO   = 4'd7,
		S_AK_SET  = 4'd8,
		S_AK_HI   = 4'd9,
		S_AK_WAIT = 4'd10,
		S_RD_LO   = 4'd11,
		S_RD_HI   = 4'd12,
		S_RA_SET  = 4'd13,
		S_RA_HI   = 4'd14
	} seq_state_t;

	// One bus tick request
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] func;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} cmd_t;

	// Line levels and status after one tick
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       no_ack;
	} res_t;

endpackage

// ===== design/i2cmbc_if.sv =====
interface i2cmbc_in_if;
	logic               valid;
	logic               ready;
	i2cmbc_pkg::cmd_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface i2cmbc_out_if;
	logic               valid;
	logic               ready;
	i2cmbc_pkg::res_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/i2cmbc_seq.sv =====
module i2cmbc_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tick_en,
	input  i2cmbc_pkg::cmd_t                    cmd,
	input  logic                                cfg_we,
	input  logic [i2cmbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_data,
	output i2cmbc_pkg::res_t                    res
);

	logic [7:0]             phase_ticks_q;
	logic [7:0]             ack_timeout_q;

	i2cmbc_pkg::seq_state_t state_q, state_d;
	logic [3:0]             bit_cnt_q, bit_cnt_d;
	logic [7:0]             shift_q, shift_d;
	logic [8:0]             phase_q, phase_d;
	logic [7:0]             wait_q, wait_d;
	logic                   ack_q, ack_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	logic                   drv_q, drv_d;
	logic [7:0]             rx_q, rx_d;
	logic                   noack_q, noack_d;

	logic                   done;
	logic                   do_enter;
	i2cmbc_pkg::seq_state_t enter_st;
	logic [8:0]             base_len;
	logic [8:0]             phase_len;
	logic [3:0]             bit_cnt_inc;
	logic                   long_phase;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cmbc_pkg::PHASE_TICKS_RST;
			ack_timeout_q <= i2cmbc_pkg::ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (i2cmbc_pkg::cfg_idx_t'(cfg_index))
				i2cmbc_pkg::CFG_PHASE_TICKS: phase_ticks_q <= cfg_data;
				i2cmbc_pkg::CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Phase length: a zero count acts as one, start and stop hold double
	assign long_phase = (state_q == i2cmbc_pkg::S_ST_HI) || (state_q == i2cmbc_pkg::S_ST_LO) ||
		(state_q == i2cmbc_pkg::S_SP_LO) || (state_q == i2cmbc_pkg::S_SP_HI);
	assign base_len    = (phase_ticks_q == 8'd0) ? 9'd1 : {1'b0, phase_ticks_q};
	assign phase_len   = long_phase ? {base_len[7:0], 1'b0} : base_len;
	assign bit_cnt_inc = bit_cnt_q + 4'd1;

	// Advance the sequencer by one tick
	always_comb begin
		state_d   = state_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		phase_d   = phase_q;
		wait_d    = wait_q;
		ack_d     = ack_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		drv_d     = drv_q;
		rx_d      = rx_q;
		noack_d   = noack_q;
		done      = 1'b0;
		do_enter  = 1'b0;
		enter_st  = i2cmbc_pkg::S_IDLE;

		priority if (state_q == i2cmbc_pkg::S_IDLE) begin
			if (cmd.cmd_valid) begin
				bit_cnt_d = 4'd0;
				do_enter  = 1'b1;
				unique case (i2cmbc_pkg::func_t'(cmd.func))
					i2cmbc_pkg::FUNC_START: enter_st = i2cmbc_pkg::S_ST_HI;
					i2cmbc_pkg::FUNC_STOP:  enter_st = i2cmbc_pkg::S_SP_LO;
					i2cmbc_pkg::FUNC_WRITE: begin
						shift_d  = cmd.tx_byte;
						enter_st = i2cmbc_pkg::S_WR_SET;
					end
					i2cmbc_pkg::FUNC_READ: begin
						shift_d  = 8'd0;
						ack_d    = cmd.send_ack;
						enter_st = i2cmbc_pkg::S_RD_LO;
					end
					default: enter_st = i2cmbc_pkg::S_IDLE;
				endcase
			end
		end else if (state_q == i2cmbc_pkg::S_AK_WAIT) begin
			// Wait for the slave to pull SDA low, give up with a stop
			if (!cmd.sda_in) begin
				scl_d   = 1'b0;
				noack_d = 1'b0;
				state_d = i2cmbc_pkg::S_IDLE;
				phase_d = 9'd0;
				done    = 1'b1;
			end else if (wait_q >= ack_timeout_q) begin
				noack_d  = 1'b1;
				do_enter = 1'b1;
				enter_st = i2cmbc_pkg::S_SP_LO;
			end else begin
				wait_d = wait_q + 8'd1;
			end
		end else if (phase_q < phase_len) begin
			phase_d = phase_q + 9'd1;
		end else begin
			unique case (state_q)
				i2cmbc_pkg::S_ST_HI: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_ST_LO;
				end
				i2cmbc_pkg::S_ST_LO: begin
					scl_d   = 1'b0;
					state_d = i2cmbc_pkg::S_IDLE;
					phase_d = 9'd0;
					done    = 1'b1;
				end
				i2cmbc_pkg::S_SP_LO: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_SP_HI;
				end
				i2cmbc_pkg::S_SP_HI: begin
					state_d = i2cmbc_pkg::S_IDLE;
					phase_d = 9'd0;
					done    = 1'b1;
				end
				i2cmbc_pkg::S_WR_SET: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_WR_HI;
				end
				i2cmbc_pkg::S_WR_HI: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_WR_LO;
				end
				i2cmbc_pkg::S_WR_LO: begin
					shift_d   = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_inc;
					do_enter  = 1'b1;
					enter_st  = bit_cnt_inc[3] ? i2cmbc_pkg::S_AK_SET : i2cmbc_pkg::S_WR_SET;
				end
				i2cmbc_pkg::S_AK_SET: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_AK_HI;
				end
				i2cmbc_pkg::S_AK_HI: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_AK_WAIT;
				end
				i2cmbc_pkg::S_RD_LO: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_RD_HI;
				end
				i2cmbc_pkg::S_RD_HI: begin
					// Sample SDA on the last tick of the high phase
					shift_d   = {shift_q[6:0], cmd.sda_in};
					bit_cnt_d = bit_cnt_inc;
					do_enter  = 1'b1;
					enter_st  = bit_cnt_inc[3] ? i2cmbc_pkg::S_RA_SET : i2cmbc_pkg::S_RD_LO;
				end
				i2cmbc_pkg::S_RA_SET: begin
					do_enter = 1'b1;
					enter_st = i2cmbc_pkg::S_RA_HI;
				end
				i2cmbc_pkg::S_RA_HI: begin
					scl_d   = 1'b0;
					rx_d    = shift_q;
					state_d = i2cmbc_pkg::S_IDLE;
					phase_d = 9'd0;
					done    = 1'b1;
				end
				default: begin
					state_d = i2cmbc_pkg::S_IDLE;
					phase_d = 9'd0;
				end
			endcase
		end

		// Enter a new phase: restart the phase count and set its line levels
		if (do_enter) begin
			state_d = enter_st;
			phase_d = 9'd1;
			unique case (enter_st)
				i2cmbc_pkg::S_ST_HI: begin
					scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
				end
				i2cmbc_pkg::S_ST_LO: begin
					scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1;
				end
				i2cmbc_pkg::S_SP_LO: begin
					scl_d = 1'b0; sda_d = 1'b0; drv_d = 1'b1;
				end
				i2cmbc_pkg::S_SP_HI: begin
					scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
				end
				i2cmbc_pkg::S_WR_SET: begin
					scl_d = 1'b0; sda_d = shift_d[7]; drv_d = 1'b1;
				end
				i2cmbc_pkg::S_AK_SET,
				i2cmbc_pkg::S_RD_LO: begin
					scl_d = 1'b0; sda_d = 1'b1; drv_d = 1'b0;
				end
				i2cmbc_pkg::S_RA_SET: begin
					scl_d = 1'b0; sda_d = ~ack_d; drv_d = 1'b1;
				end
				i2cmbc_pkg::S_WR_HI,
				i2cmbc_pkg::S_AK_HI,
				i2cmbc_pkg::S_RD_HI,
				i2cmbc_pkg::S_RA_HI: scl_d = 1'b1;
				i2cmbc_pkg::S_WR_LO: scl_d = 1'b0;
				i2cmbc_pkg::S_AK_WAIT: wait_d = 8'd0;
				default: begin
					state_d = i2cmbc_pkg::S_IDLE;
					phase_d = 9'd0;
				end
			endcase
		end
	end

	// Hold sequencer state between ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= i2cmbc_pkg::S_IDLE;
			bit_cnt_q <= 4'd0;
			shift_q   <= 8'd0;
			phase_q   <= 9'd0;
			wait_q    <= 8'd0;
			ack_q     <= 1'b0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			drv_q     <= 1'b1;
			rx_q      <= 8'd0;
			noack_q   <= 1'b0;
		end else if (tick_en) begin
			state_q   <= state_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			phase_q   <= phase_d;
			wait_q    <= wait_d;
			ack_q     <= ack_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			drv_q     <= drv_d;
			rx_q      <= rx_d;
			noack_q   <= noack_d;
		end
	end

	// Result of this tick; released SDA reads as high
	always_comb begin
		res.scl_level = scl_d;
		res.sda_level = drv_d ? sda_d : 1'b1;
		res.sda_drive = drv_d;
		res.busy_res  = (state_d != i2cmbc_pkg::S_IDLE);
		res.done_res  = done;
		res.rx_byte   = rx_d;
		res.no_ack    = noack_d;
	end

endmodule

// ===== design/i2cmbc_out_buf.sv =====
module i2cmbc_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  i2cmbc_pkg::res_t    push_data,
	output logic                push_ready,
	output logic                out_valid,
	output i2cmbc_pkg::res_t    out_data,
	input  logic                out_ready
);

	i2cmbc_pkg::res_t main_q;
	i2cmbc_pkg::res_t skid_q;
	logic             main_vld_q;
	logic             skid_vld_q;
	logic             pop;
	logic             load_main;
	logic             load_skid;
	logic             main_from_skid;

	assign pop        = main_vld_q && out_ready;
	assign push_ready = !skid_vld_q;
	assign out_valid  = main_vld_q;
	assign out_data   = main_q;

	// Steer the incoming result to the head or the skid slot
	assign main_from_skid = skid_vld_q && pop;
	assign load_main      = push && (!main_vld_q || pop) && !skid_vld_q;
	assign load_skid      = push && main_vld_q && !pop && !skid_vld_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (load_main || main_from_skid) begin
				main_vld_q <= 1'b1;
			end else if (pop) begin
				main_vld_q <= 1'b0;
			end
			if (load_skid) begin
				skid_vld_q <= 1'b1;
			end else if (main_from_skid) begin
				skid_vld_q <= 1'b0;
			end
		end
	end

	// Hold result payloads
	always_ff @(posedge clk) begin
		if (main_from_skid) begin
			main_q <= skid_q;
		end else if (load_main) begin
			main_q <= push_data;
		end
		if (load_skid) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== design/i2c_master_byte_controller_top.sv =====
// I2C master byte controller.
// in_ch carries one bus tick per request: the sampled SDA level and an
// optional command (start, stop, write byte with ACK check, read byte with
// ACK or NACK answer). A command is taken only while no command is running.
// out_ch returns exactly one result per tick: SCL level, SDA level and drive
// enable, busy, done, the last received byte and the no-ACK flag.
// Throughput: one tick per clock cycle while in_ch.ready is high; the sequencer
// is a single combinational pass from its state registers to the result.
// Each result is registered in the result buffer before out_ch shows it.
// A two-entry result buffer sits between the sequencer and out_ch, so a tick
// is taken while a result still waits; in_ch.ready drops only when both
// entries are held, i.e. once the receiver holds off while a result waits and
// another tick is taken.
// Reset: lines SCL high, SDA high and driven, sequencer idle, status clear,
// phase_ticks 2, ack_timeout 250, result buffer empty.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are meant to happen only while the controller is idle.
module i2c_master_byte_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	i2cmbc_in_if.sink                           in_ch,
	i2cmbc_out_if.source                        out_ch,
	input  logic                                cfg_we,
	input  logic [i2cmbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                          cfg_data
);

	logic             tick_en;
	logic             buf_ready;
	i2cmbc_pkg::res_t tick_res;

	assign in_ch.ready = buf_ready;
	assign tick_en     = in_ch.valid && buf_ready;

	// Bus sequencer
	i2cmbc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_en   (tick_en),
		.cmd       (in_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (tick_res)
	);

	// Result buffer
	i2cmbc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (tick_en),
		.push_data  (tick_res),
		.push_ready (buf_ready),
		.out_valid  (out_ch.valid),
		.out_data   (out_ch.data),
		.out_ready  (out_ch.ready)
	);

endmodule

// ===== design/i2cmbc_chk.sv =====
module i2cmbc_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                out_valid,
	input  logic                out_ready,
	input  i2cmbc_pkg::res_t    out_data
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A tick taken while no result waits shows a result on the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("taken tick produced no result");

	// Backpressure only while a result is waiting
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// A completing command leaves the controller idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done with busy still set");

endmodule

bind i2c_master_byte_controller_top i2cmbc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

// ===== verif/tb_i2c_master_byte_controller_top.sv =====
module tb_i2c_master_byte_controller_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmbc_pkg::*;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int SEG_TICKS    = 60;
	localparam int HOLD_CYCLES  = 150;
	localparam int NEVER_ACK    = 300;
	localparam int NUM_SEGS     = 4;

	// How often a side of the bus inserts idle cycles
	typedef enum int {
		PACE_NONE,
		PACE_FULL,
		PACE_SPARSE
	} pace_t;

	// One directed command with the target's ACK behavior
	typedef struct packed {
		logic       issue;
		func_t      op;
		logic [7:0] data;
		logic       ack;
		logic [8:0] ack_delay;
		logic       junk;
		logic       sda;
		logic       typed;
		res_t       first;
	} dir_row_t;

	localparam res_t NO_RES          = '0;
	localparam res_t RES_AFTER_RESET = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam res_t RES_START_ENTRY = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam res_t RES_WR_ONE      = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam res_t RES_WR_ZERO     = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};

	// Directed commands at reset settings (2 ticks per phase, timeout 250)
	localparam dir_row_t DIR_TABLE [19] = '{
		'{1'b0, FUNC_START, 8'h00, 1'b0, 9'd0,   1'b0, 1'b1, 1'b1, RES_AFTER_RESET},
		'{1'b1, FUNC_START, 8'h00, 1'b0, 9'd0,   1'b0, 1'b1, 1'b1, RES_START_ENTRY},
		'{1'b1, FUNC_WRITE, 8'hff, 1'b0, 9'd0,   1'b0, 1'b0, 1'b1, RES_WR_ONE},
		'{1'b1, FUNC_WRITE, 8'h00, 1'b1, 9'd3,   1'b0, 1'b1, 1'b1, RES_WR_ZERO},
		'{1'b1, FUNC_WRITE, 8'ha5, 1'b0, 9'd1,   1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, FUNC_READ,  8'h00, 1'b1, 9'd0,   1'b1, 1'b1, 1'b0, NO_RES},
		'{1'b1, FUNC_READ,  8'hff, 1'b0, 9'd0,   1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, FUNC_STOP,  8'h00, 1'b0, 9'd0,   1'b0, 1'b1, 1'b0, NO_RES},
		'{1'b0, FUNC_STOP,  8'h00, 1'b0, 9'd0,   1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, FUNC_START, 8'hff, 1'b1, 9'd0,   1'b0, 1'b0, 1'b0, NO_RES},
		'{1'b1, FUNC_START, 8'h00, 1'b0, 9'd0,   1'b1, 1'b1, 1'b0, NO_RES},
		'{1'b1, FUNC_WRITE, 8'h5a, 1'b0, 9'd2,   1'b0, 1'b1, 1'b0, NO_RES},
		'{1'b0, FUNC_READ,  8'h00, 1'b0, 9'd0,   1'b0, 1'b1, 1'b0, NO_RES},
		'{1'b1, FUNC_WRITE, 8'h80, 1'b1, 9'd251, 1'b1, 1'b0, 1'b0, NO_RES},
		'{1'b1, FUNC_STOP,  8'hff, 1'b1, 9'd0,   1'b1, 1'b0, 1'b0, NO_RES},
		'{1'b1, FUNC_READ,  8'h00, 1'b0, 9'd0,   1'b0, 1'b1, 1'b0, NO_RES},
		'{1'b1, FUNC_WRITE, 8'h01, 1'b0, 9'd0,   1'b1, 1'b1, 1'b0, NO_RES},
		'{1'b1, FUNC_STOP,  8'h00, 1'b0, 9'd0,   1'b0, 1'b1, 1'b0, NO_RES},
		'{1'b0, FUNC_WRITE, 8'h00, 1'b0, 9'd0,   1'b0, 1'b0, 1'b0, NO_RES}
	};

	// Settings per random segment: extremes, zero values and common cases
	localparam logic [7:0] SEG_PHASE   [NUM_SEGS] = '{8'd1, 8'd0, 8'd128, 8'd1};
	localparam logic [7:0] SEG_TIMEOUT [NUM_SEGS] = '{8'd255, 8'd0, 8'd250, 8'd7};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic       cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	i2cmbc_in_if  in_ch ();
	i2cmbc_out_if out_ch ();

	i2c_master_byte_controller_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Controller copy: settings and sequencer state
	logic [7:0] phase_ticks_q = PHASE_TICKS_RST;
	logic [7:0] ack_timeout_q = ACK_TIMEOUT_RST;
	seq_state_t bus_state     = S_IDLE;
	logic [3:0] bits_done     = '0;
	logic [7:0] shifter       = '0;
	logic [8:0] phase_cnt     = '0;
	logic [7:0] ack_wait_cnt  = '0;
	logic       answer_ack    = 1'b0;
	logic       scl_q         = 1'b1;
	logic       sda_q         = 1'b1;
	logic       drv_q         = 1'b1;
	logic [7:0] rx_q          = '0;
	logic       nack_q        = 1'b0;

	res_t  line_status_q [$];
	int    mismatches    = 0;
	int    ticks_sent    = 0;
	int    cycle_cnt     = 0;
	int    ack_delay_cur = 0;
	pace_t tx_pace       = PACE_NONE;
	pace_t rx_pace       = PACE_NONE;
	bit    rx_hold       = 1'b0;

	function automatic logic [8:0] phase_length(input seq_state_t st);
		logic [8:0] p;
		p = (phase_ticks_q == 8'd0) ? 9'd1 : {1'b0, phase_ticks_q};
		// start and stop levels hold for two phases
		if (st inside {S_ST_HI, S_ST_LO, S_SP_LO, S_SP_HI})
			return p << 1;
		return p;
	endfunction

	function automatic void enter_phase(input seq_state_t st);
		bus_state = st;
		phase_cnt = 9'd1;
		case (st)
			S_ST_HI, S_SP_HI: {scl_q, sda_q, drv_q} = 3'b111;
			S_ST_LO:          {scl_q, sda_q, drv_q} = 3'b101;
			S_SP_LO:          {scl_q, sda_q, drv_q} = 3'b001;
			S_WR_SET:         {scl_q, sda_q, drv_q} = {1'b0, shifter[7], 1'b1};
			S_AK_SET, S_RD_LO: {scl_q, sda_q, drv_q} = 3'b010;
			S_RA_SET:         {scl_q, sda_q, drv_q} = {1'b0, ~answer_ack, 1'b1};
			S_WR_HI, S_AK_HI, S_RD_HI, S_RA_HI: scl_q = 1'b1;
			S_WR_LO:          scl_q = 1'b0;
			S_AK_WAIT:        ack_wait_cnt = '0;
			default: begin
				bus_state = S_IDLE;
				phase_cnt = '0;
			end
		endcase
	endfunction

	// Advance the controller copy by one bus tick and return the line status
	function automatic res_t sequence_tick(input cmd_t tick);
		res_t r;
		logic fin;
		fin = 1'b0;
		if (bus_state == S_IDLE) begin
			if (tick.cmd_valid) begin
				bits_done = '0;
				case (func_t'(tick.func))
					FUNC_START: enter_phase(S_ST_HI);
					FUNC_STOP:  enter_phase(S_SP_LO);
					FUNC_WRITE: begin
						shifter = tick.tx_byte;
						enter_phase(S_WR_SET);
					end
					default: begin
						shifter = '0;
						answer_ack = tick.send_ack;
						enter_phase(S_RD_LO);
					end
				endcase
			end
		end else if (bus_state == S_AK_WAIT) begin
			// low sample is the ACK; past the timeout give up with a stop
			if (!tick.sda_in) begin
				scl_q = 1'b0;
				nack_q = 1'b0;
				fin = 1'b1;
			end else if (ack_wait_cnt >= ack_timeout_q) begin
				nack_q = 1'b1;
				enter_phase(S_SP_LO);
			end else begin
				ack_wait_cnt = ack_wait_cnt + 8'd1;
			end
		end else if (phase_cnt < phase_length(bus_state)) begin
			phase_cnt = phase_cnt + 9'd1;
		end else begin
			case (bus_state)
				S_ST_HI:  enter_phase(S_ST_LO);
				S_ST_LO: begin
					scl_q = 1'b0;
					fin = 1'b1;
				end
				S_SP_LO:  enter_phase(S_SP_HI);
				S_SP_HI:  fin = 1'b1;
				S_WR_SET: enter_phase(S_WR_HI);
				S_WR_HI:  enter_phase(S_WR_LO);
				S_WR_LO: begin
					shifter = shifter << 1;
					bits_done = bits_done + 4'd1;
					enter_phase(bits_done < 4'd8 ? S_WR_SET : S_AK_SET);
				end
				S_AK_SET: enter_phase(S_AK_HI);
				S_AK_HI:  enter_phase(S_AK_WAIT);
				S_RD_LO:  enter_phase(S_RD_HI);
				S_RD_HI: begin
					shifter = {shifter[6:0], tick.sda_in};
					bits_done = bits_done + 4'd1;
					enter_phase(bits_done < 4'd8 ? S_RD_LO : S_RA_SET);
				end
				S_RA_SET: enter_phase(S_RA_HI);
				S_RA_HI: begin
					scl_q = 1'b0;
					rx_q = shifter;
					fin = 1'b1;
				end
				default:  enter_phase(S_IDLE);
			endcase
		end
		if (fin) begin
			bus_state = S_IDLE;
			phase_cnt = '0;
		end
		r.scl_level = scl_q;
		r.sda_level = drv_q ? sda_q : 1'b1;
		r.sda_drive = drv_q;
		r.busy_res  = (bus_state != S_IDLE);
		r.done_res  = fin;
		r.rx_byte   = rx_q;
		r.no_ack    = nack_q;
		return r;
	endfunction

	function automatic int draw_gap(input pace_t pace);
		case (pace)
			PACE_NONE: return 0;
			PACE_FULL: return $urandom_range(0, 18);
			default:   return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	function automatic int pick_ack_delay();
		case ($urandom_range(0, 15))
			0:       return NEVER_ACK;
			1, 2:    return $urandom_range(0, ack_timeout_q + 2);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic cmd_t make_cmd(input func_t op, input logic [7:0] data,
			input logic ack);
		cmd_t c;
		c.cmd_valid = 1'b1;
		c.func      = op;
		c.tx_byte   = data;
		c.send_ack  = ack;
		c.sda_in    = 1'($urandom);
		return c;
	endfunction

	function automatic cmd_t idle_tick();
		cmd_t c;
		c = cmd_t'(13'($urandom));
		c.cmd_valid = 1'b0;
		return c;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Offer one tick request and log its expected line status once taken
	task automatic send_tick(input cmd_t tick, input bit use_typed = 1'b0,
			input res_t typed_res = '0);
		int gap;
		res_t predicted;
		gap = draw_gap(tx_pace);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		// target holds SDA high for its planned number of ACK samples
		if (bus_state == S_AK_WAIT)
			tick.sda_in = (ack_wait_cnt < ack_delay_cur);
		in_ch.valid = 1'b1;
		in_ch.data = tick;
		do @(posedge clk); while (!in_ch.ready);
		predicted = sequence_tick(tick);
		line_status_q.push_back(use_typed ? typed_res : predicted);
		ticks_sent++;
	endtask

	// Issue one tick, then feed ticks until the controller is idle again
	task automatic run_command(input cmd_t first_tick, input int delay, input bit junk,
			input bit use_typed = 1'b0, input res_t typed_res = '0);
		cmd_t tick;
		ack_delay_cur = delay;
		send_tick(first_tick, use_typed, typed_res);
		while (bus_state != S_IDLE) begin
			tick = idle_tick();
			if (junk && $urandom_range(0, 5) == 0)
				tick.cmd_valid = 1'b1;
			send_tick(tick);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (line_status_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_setting(input cfg_idx_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_PHASE_TICKS: phase_ticks_q = value;
			default:         ack_timeout_q = value;
		endcase
	endtask

	// Bus transfer: mostly start, writes, reads, stop; sometimes a stray command
	task automatic run_transfer();
		int n;
		bit junk;
		junk = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 6) == 0) begin
			run_command(make_cmd(func_t'(2'($urandom)), 8'($urandom), 1'($urandom)),
				pick_ack_delay(), junk);
			return;
		end
		run_command(make_cmd(FUNC_START, 8'($urandom), 1'($urandom)), 0, junk);
		n = $urandom_range(1, 3);
		repeat (n) begin
			run_command(make_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom)),
				pick_ack_delay(), junk);
			// a missing ACK already ends the transfer with a stop
			if (nack_q)
				return;
		end
		if ($urandom_range(0, 3) == 0)
			run_command(make_cmd(FUNC_START, 8'($urandom), 1'($urandom)), 0, junk);
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			run_command(make_cmd(FUNC_READ, 8'($urandom),
				(i != n - 1) ^ ($urandom_range(0, 7) == 0)), 0, junk);
		end
		run_command(make_cmd(FUNC_STOP, 8'($urandom), 1'($urandom)), 0, junk);
	endtask

	// Stimulus: directed commands, then random transfers per settings segment
	initial begin
		cmd_t tick;
		int seg_base;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_PHASE_TICKS;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < $size(DIR_TABLE); i++) begin
			tick = make_cmd(DIR_TABLE[i].op, DIR_TABLE[i].data, DIR_TABLE[i].ack);
			tick.cmd_valid = DIR_TABLE[i].issue;
			tick.sda_in = DIR_TABLE[i].sda;
			run_command(tick, int'(DIR_TABLE[i].ack_delay), DIR_TABLE[i].junk,
				DIR_TABLE[i].typed, DIR_TABLE[i].first);
		end

		for (int s = 0; s < NUM_SEGS; s++) begin
			drain_results();
			write_setting(CFG_PHASE_TICKS, SEG_PHASE[s]);
			write_setting(CFG_ACK_TIMEOUT, SEG_TIMEOUT[s]);
			tx_pace = pace_t'($urandom_range(0, 2));
			rx_pace = pace_t'($urandom_range(0, 2));
			seg_base = ticks_sent;
			if (SEG_PHASE[s] >= 8'd128) begin
				// long phases that need the doubled count's top bit: one start, no idling
				tx_pace = PACE_NONE;
				rx_pace = PACE_NONE;
				run_command(make_cmd(FUNC_START, 8'($urandom), 1'($urandom)), 0, 1'b1);
			end else begin
				// stall the receiver for a long stretch while requests keep coming
				if (s == 3) begin
					tx_pace = PACE_NONE;
					rx_hold = 1'b1;
				end
				while (ticks_sent - seg_base < SEG_TICKS) begin
					if ($urandom_range(0, 3) == 0)
						run_command(idle_tick(), 0, 1'b0);
					if ($urandom_range(0, 9) == 0)
						drain_results();
					run_transfer();
				end
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("i2c_master_byte_controller_top: match");
		end else begin
			$display("i2c_master_byte_controller_top: mismatch");
		end
		$finish;
	end

	// Receiver: take results with random stalls and one long hold
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		while (!arst_n) @(negedge clk);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			stall = draw_gap(rx_pace);
			if (stall > 0) begin
				@(negedge clk);
				out_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// Compare each result with the oldest expected line status
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (line_status_q.size() == 0) begin
				$error("result with no tick waiting: %h", out_ch.data);
				mismatches++;
			end else begin
				want = line_status_q.pop_front();
				check_field("scl_level", 8'(want.scl_level), 8'(out_ch.data.scl_level));
				check_field("sda_level", 8'(want.sda_level), 8'(out_ch.data.sda_level));
				check_field("sda_drive", 8'(want.sda_drive), 8'(out_ch.data.sda_drive));
				check_field("busy_res", 8'(want.busy_res), 8'(out_ch.data.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(out_ch.data.done_res));
				check_field("rx_byte", want.rx_byte, out_ch.data.rx_byte);
				check_field("no_ack", 8'(want.no_ack), 8'(out_ch.data.no_ack));
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("i2c_master_byte_controller_top: mismatch");
			$finish;
		end
	end

endmodule
